// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker module, maf_checker.
// Needs a clk in the scope where a macro is used, and an active-low rst_n for MAF_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/maf_pkg.sv =====
// Constants for the moving average filter: window, field widths and the
// reciprocal used for the divide by the window length. No dependencies.
package maf_pkg;

  localparam int WINDOW   = 10;
  localparam int SAMPLE_W = 12;
  localparam int MEAN_W   = 16;

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

  // sum*16/WINDOW as (sum*16 * RECIP) >> DIV_S, exact for DIV_N-bit operands
  localparam int DIV_N   = SUM_W + 4;
  localparam int DIV_S   = DIV_N + $clog2(WINDOW);
  localparam int RECIP_W = DIV_N + 1;
  localparam longint RECIP_L = ((64'(1) << DIV_S) + WINDOW - 1) / WINDOW;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam int PROD_W  = DIV_S + MEAN_W;

endpackage

// ===== rtl/moving_average_filter_core.sv =====
// Moving average filter core: sample ring in RAM, running sum, scaled mean.
// Depends on maf_pkg and maf_ram.
//
// Usage:
// - Input channel in_valid/in_stall/in_sample: one 12-bit converter code per
//   beat, taken at an edge with in_valid high and in_stall low.
// - Output channel out_valid/out_stall/out_mean_q4: one beat per input beat,
//   the mean of the last WINDOW samples in unsigned 12.4, truncated.
// - Order: a taken sample is registered with its ring read, then the sum
//   update is registered, then the reciprocal multiply drives out_*.
// - Throughput: one beat per cycle while in_stall is low; the ring RAM is
//   read once per input and written once per sum update, each on its own port.
// - Reset: clears the pointer, the sum and the per-entry valid bits, so the
//   ring reads as zeros and the first WINDOW-1 results average in zeros.
//   No clearing pass; beats are taken right after reset.
// - Stall: out_stall holds the output beat; the three stages keep filling,
//   and in_stall rises only once all of them hold a beat.
module moving_average_filter_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [maf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [maf_pkg::MEAN_W-1:0]   out_mean_q4
);

  logic                         in_fire;
  logic [maf_pkg::PTR_W-1:0]    ptr_r;
  logic [maf_pkg::PTR_W-1:0]    ptr_nxt;

  logic                         s1_vld_r;
  logic [maf_pkg::PTR_W-1:0]    s1_slot_r;
  logic [maf_pkg::SAMPLE_W-1:0] s1_smp_r;
  logic                         s2_vld_r;
  logic [maf_pkg::SUM_W-1:0]    s2_sum_r;
  logic                         out_vld_r;
  logic [maf_pkg::PROD_W-1:0]   prod_r;
  logic [maf_pkg::PROD_W-1:0]   prod_nxt;

  logic                         rdy1;
  logic                         rdy2;
  logic                         rdy3;
  logic                         s1_adv;

  logic [maf_pkg::WINDOW-1:0]   ent_vld_r;
  logic [maf_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [maf_pkg::SAMPLE_W-1:0] old_smp;
  logic [maf_pkg::SUM_W-1:0]    sum_r;
  logic [maf_pkg::SUM_W-1:0]    sum_nxt;

  assign rdy3     = !out_vld_r || !out_stall;
  assign rdy2     = !s2_vld_r || rdy3;
  assign rdy1     = !s1_vld_r || rdy2;
  assign in_stall = !rdy1;
  assign in_fire  = in_valid && rdy1;
  assign s1_adv   = s1_vld_r && rdy2;

  // pointer advances before the write; stray values wrap to zero
  assign ptr_nxt = (ptr_r >= maf_pkg::PTR_W'(maf_pkg::WINDOW - 1)) ? '0 : ptr_r + 1'b1;

  maf_ram #(
    .WIDTH  (maf_pkg::SAMPLE_W),
    .DEPTH  (maf_pkg::WINDOW),
    .ADDR_W (maf_pkg::PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_slot_r),
    .wdata (s1_smp_r),
    .re    (in_fire),
    .raddr (ptr_nxt),
    .rdata (ram_rdata)
  );

  // entries not written since reset read as zero
  assign old_smp = ent_vld_r[s1_slot_r] ? ram_rdata : '0;
  assign sum_nxt = sum_r - maf_pkg::SUM_W'(old_smp) + maf_pkg::SUM_W'(s1_smp_r);
  assign prod_nxt = maf_pkg::PROD_W'({s2_sum_r, 4'b0000}) *
                    maf_pkg::PROD_W'(maf_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r     <= '0;
      sum_r     <= '0;
      ent_vld_r <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_fire) begin
        ptr_r <= ptr_nxt;
      end
      if (rdy1) begin
        s1_vld_r <= in_valid;
      end
      if (rdy2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (rdy3) begin
        out_vld_r <= s2_vld_r;
      end
      if (s1_adv) begin
        sum_r                <= sum_nxt;
        ent_vld_r[s1_slot_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_slot_r <= ptr_nxt;
      s1_smp_r  <= in_sample;
    end
    if (s1_adv) begin
      s2_sum_r <= sum_nxt;
    end
    if (rdy3 && s2_vld_r) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_mean_q4 = prod_r[maf_pkg::DIV_S +: maf_pkg::MEAN_W];

endmodule

// ===== rtl/maf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependencies.
module maf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/maf_checker.sv =====
// Port-level checks for moving_average_filter_core, bound into that module.
// Depends on assert_macros.svh and maf_pkg.
`include "assert_macros.svh"

module maf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [maf_pkg::SAMPLE_W-1:0] in_sample,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [maf_pkg::MEAN_W-1:0]   out_mean_q4
);

  `MAF_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_sample), "stalled input beat changed")
  `MAF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_mean_q4), "stalled output beat changed")
  `MAF_ASSERT(a_mean_range, out_valid |-> out_mean_q4 <= 16'd65520, "mean above full scale")
  `MAF_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without output backpressure")
  `MAF_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output beat right after reset")

endmodule

bind moving_average_filter_core maf_checker u_maf_checker (.*);
